@@ src/channel_aware_frame_fanout_defines.svh @@
// ----------------------------------------------------------------------------
// channel_aware_frame_fanout_defines.svh
// Assertion macros for the frame fanout checker.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_AWARE_FRAME_FANOUT_DEFINES_SVH
`define CHANNEL_AWARE_FRAME_FANOUT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define CAFF_ASSERT_NOW(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define CAFF_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

@@ src/caff_pkg.sv @@
// ----------------------------------------------------------------------------
// caff_pkg
// Constants and types shared by the frame fanout modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package caff_pkg;

   // Table size and frame limits
   localparam int PEER_SLOTS          = 32;
   localparam int MAX_PAYLOAD         = 8192 + 64;
   localparam int SHORTEST_FRAME      = 28;
   localparam int CHANNEL_HDR_LEN     = 40;
   localparam int CHANNEL_HDR_VERSION = 2;
   localparam int RESET_HOP_LIMIT     = 8;

   // Field widths fixed by the item format
   localparam int SLOT_W = 5;
   localparam int MASK_W = 32;
   localparam int FREQ_W = 16;
   localparam int TTL_W  = 8;

   // Table indexing
   localparam int SLOT_IDX_W = $clog2(PEER_SLOTS);
   localparam int SLOT_EXT_W = (SLOT_IDX_W > SLOT_W) ? SLOT_IDX_W : SLOT_W;
   localparam int MASK_SLOTS = (PEER_SLOTS < MASK_W) ? PEER_SLOTS : MASK_W;

   // Operation codes; the fourth code is a no-op
   typedef enum logic [1:0] {
      OP_FRAME  = 2'd0,
      OP_ATTACH = 2'd1,
      OP_DETACH = 2'd2
   } caff_op_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [SLOT_W-1:0] peer_slot;
      logic              peer_bridge_link;
      logic [13:0]       payload_length;
      logic [15:0]       header_version;
      logic [FREQ_W-1:0] chan_freq;
      logic [FREQ_W-1:0] sec_freq;
      logic [TTL_W-1:0]  ttl_in;
   } caff_req_type;

   typedef struct packed {
      logic [MASK_W-1:0] local_mask;
      logic [MASK_W-1:0] bridge_mask;
      logic [TTL_W-1:0]  ttl_out;
      logic              dropped;
   } caff_rsp_type;

   // Current contents of the peer table
   typedef struct packed {
      logic [PEER_SLOTS-1:0]             valid;
      logic [PEER_SLOTS-1:0]             bridge_link;
      logic [PEER_SLOTS-1:0][FREQ_W-1:0] chan_freq;
      logic [PEER_SLOTS-1:0][FREQ_W-1:0] sec_freq;
   } caff_table_type;

   // One-slot write into the peer table
   typedef struct packed {
      logic                  write;
      logic [SLOT_IDX_W-1:0] index;
      logic                  valid;
      logic                  bridge_link;
      logic [FREQ_W-1:0]     chan_freq;
      logic [FREQ_W-1:0]     sec_freq;
   } caff_update_type;

endpackage

@@ src/caff_table.sv @@
// ----------------------------------------------------------------------------
// caff_table
// Peer slot table in flip-flops with a single-slot write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module caff_table (
   input  logic                     clock,
   input  logic                     reset,
   input  caff_pkg::caff_update_type upd,
   output caff_pkg::caff_table_type  tbl
);
   import caff_pkg::*;

   logic [PEER_SLOTS-1:0]             valid_ff, valid_in;
   logic [PEER_SLOTS-1:0]             bridge_ff, bridge_in;
   logic [PEER_SLOTS-1:0][FREQ_W-1:0] chan_ff, chan_in;
   logic [PEER_SLOTS-1:0][FREQ_W-1:0] bond_ff, bond_in;

   // Next-state: overwrite the addressed slot
   always_comb begin
      valid_in  = valid_ff;
      bridge_in = bridge_ff;
      chan_in   = chan_ff;
      bond_in   = bond_ff;
      if (upd.write) begin
         valid_in[upd.index]  = upd.valid;
         bridge_in[upd.index] = upd.bridge_link;
         chan_in[upd.index]   = upd.chan_freq;
         bond_in[upd.index]   = upd.sec_freq;
      end
   end

   // Only the valid bits need reset; attach rewrites the rest of a slot
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bridge_ff <= bridge_in;
      chan_ff   <= chan_in;
      bond_ff   <= bond_in;
   end

   assign tbl.valid       = valid_ff;
   assign tbl.bridge_link = bridge_ff;
   assign tbl.chan_freq   = chan_ff;
   assign tbl.sec_freq    = bond_ff;

endmodule

@@ src/caff_decide.sv @@
// ----------------------------------------------------------------------------
// caff_decide
// Per-item decision: slot attach/detach, frame checks, TTL and fanout masks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module caff_decide (
   input  caff_pkg::caff_req_type   req,
   input  caff_pkg::caff_table_type tbl,
   input  logic [7:0]               hop_limit,
   output caff_pkg::caff_rsp_type   rsp,
   output caff_pkg::caff_update_type upd
);
   import caff_pkg::*;

   logic [SLOT_EXT_W-1:0] slot_ext;
   logic [SLOT_IDX_W-1:0] idx;
   logic                  in_table;
   logic                  len_ok;
   logic                  chan_ok;
   logic                  sender_valid;
   logic                  sender_bridge;
   logic [FREQ_W-1:0]     txf;
   logic [FREQ_W-1:0]     txb;
   logic [TTL_W-1:0]      tout;
   logic                  to_bridges;
   logic [MASK_W-1:0]     lmask;
   logic [MASK_W-1:0]     bmask;

   // Receiver channel match, HT20/HT40 rules; zero means unknown
   function automatic logic freq_match(input logic [FREQ_W-1:0] tx,
                                       input logic [FREQ_W-1:0] txbond,
                                       input logic [FREQ_W-1:0] rx,
                                       input logic [FREQ_W-1:0] rxbond);
      logic hit;
      if (tx == '0 || rx == '0) begin
         hit = 1'b1;
      end else if (txbond != '0) begin
         hit = (rx == tx && (rxbond == txbond || rxbond == '0)) ||
               (rx == txbond && rxbond == '0);
      end else begin
         hit = (rx == tx) || (rxbond != '0 && tx == rxbond);
      end
      return hit;
   endfunction

   // Sender lookup and frame qualification
   assign slot_ext      = SLOT_EXT_W'(req.peer_slot);
   assign idx           = slot_ext[SLOT_IDX_W-1:0];
   assign in_table      = 32'(req.peer_slot) < 32'(PEER_SLOTS);
   assign len_ok        = 32'(req.payload_length) >= 32'(SHORTEST_FRAME) &&
                          32'(req.payload_length) <= 32'(MAX_PAYLOAD);
   assign chan_ok       = 32'(req.payload_length) >= 32'(CHANNEL_HDR_LEN) &&
                          32'(req.header_version) >= 32'(CHANNEL_HDR_VERSION);
   assign sender_valid  = in_table && tbl.valid[idx];
   assign sender_bridge = tbl.bridge_link[idx];
   assign txf           = chan_ok ? req.chan_freq : '0;
   assign txb           = chan_ok ? req.sec_freq : '0;

   // Hop counter: decrement from bridges, stamp default from local senders
   always_comb begin
      if (sender_bridge) begin
         tout       = (req.ttl_in == '0) ? '0 : req.ttl_in - TTL_W'(1);
         to_bridges = tout != '0;
      end else begin
         tout       = hop_limit;
         to_bridges = 1'b1;
      end
   end

   // Fanout masks, one independent test per slot
   always_comb begin
      lmask = '0;
      bmask = '0;
      for (int i = 0; i < MASK_SLOTS; i++) begin
         if (tbl.valid[i] && 32'(i) != 32'(req.peer_slot)) begin
            if (tbl.bridge_link[i]) begin
               bmask[i] = to_bridges;
            end else begin
               lmask[i] = freq_match(txf, txb, tbl.chan_freq[i], tbl.sec_freq[i]);
            end
         end
      end
   end

   // Result and table write per operation
   always_comb begin
      rsp       = '0;
      upd       = '0;
      upd.index = idx;
      unique case (req.operation)
         OP_ATTACH: begin
            upd.write       = in_table;
            upd.valid       = 1'b1;
            upd.bridge_link = req.peer_bridge_link;
         end
         OP_DETACH: begin
            upd.write = in_table;
         end
         OP_FRAME: begin
            if (!len_ok || !sender_valid) begin
               rsp.dropped = 1'b1;
            end else begin
               rsp.local_mask  = lmask;
               rsp.bridge_mask = bmask;
               rsp.ttl_out     = tout;
               // local sender refreshes its own channels
               if (!sender_bridge && txf != '0) begin
                  upd.write     = 1'b1;
                  upd.valid     = 1'b1;
                  upd.chan_freq = txf;
                  upd.sec_freq  = txb;
               end
            end
         end
         default: begin
            // unused operation code: no effect, zero result
         end
      endcase
   end

endmodule

@@ src/channel_aware_frame_fanout.sv @@
// ----------------------------------------------------------------------------
// channel_aware_frame_fanout
// Peer table and frame fanout decision with valid/ready request and response.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle when not stalled and returns one
// result per item, in order. An accepted item is held in an input register,
// the peer-table lookup and the per-slot channel match run in one pass, and
// the result lands in the output register, from which it is presented on
// rsp_, while the table update for that item commits at the same edge.
// Because of that, the next item always sees the table left by the one before
// it. The input stalls only while a result waits in the output register and
// the input register is also full. Reset clears every slot's valid bit at
// once, so items are accepted as soon as reset is released. The hop limit
// register must be written through csr_ only while no item is in flight;
// the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module channel_aware_frame_fanout (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  caff_pkg::caff_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output caff_pkg::caff_rsp_type rsp_data,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data
);
   import caff_pkg::*;

   logic            s1_valid_ff, s1_valid_in;
   caff_req_type    s1_req_ff, s1_req_in;
   logic            rsp_valid_ff, rsp_valid_in;
   caff_rsp_type    rsp_ff, rsp_in;
   logic [7:0]      hop_ff, hop_in;
   logic            accept;
   logic            advance;
   caff_rsp_type    dec_rsp;
   caff_update_type dec_upd;
   caff_update_type tbl_upd;
   caff_table_type  tbl;

   // Handshake: the input stage moves on when the output register frees up
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // Input register
   always_comb begin
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_req_in   = accept ? req_data : s1_req_ff;
   end

   // Output register
   always_comb begin
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = advance ? dec_rsp : rsp_ff;
   end

   // Hop limit register
   assign hop_in = csr_write_enable ? csr_write_data : hop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hop_ff       <= 8'(RESET_HOP_LIMIT);
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hop_ff       <= hop_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   // Decision logic
   caff_decide u_decide (
      .req       (s1_req_ff),
      .tbl       (tbl),
      .hop_limit (hop_ff),
      .rsp       (dec_rsp),
      .upd       (dec_upd)
   );

   // Table write commits only when the item's result moves into the output register
   always_comb begin
      tbl_upd       = dec_upd;
      tbl_upd.write = dec_upd.write && advance;
   end

   caff_table u_table (
      .clock (clock),
      .reset (reset),
      .upd   (tbl_upd),
      .tbl   (tbl)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ src/caff_checker.sv @@
// ----------------------------------------------------------------------------
// caff_checker
// Port-level checks on the frame fanout block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "channel_aware_frame_fanout_defines.svh"

module caff_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input caff_pkg::caff_rsp_type rsp_data
);
   import caff_pkg::*;

   // A stalled result holds its value
   `CAFF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // Input stalls only when the output side is full and stalled
   `CAFF_ASSERT_NOW(a_stall_cause, !req_ready, rsp_valid && !rsp_ready, "input stalled without output backpressure")

   // A dropped frame reaches nobody
   `CAFF_ASSERT_NOW(a_drop_empty, rsp_valid && rsp_data.dropped, rsp_data.local_mask == '0 && rsp_data.bridge_mask == '0 && rsp_data.ttl_out == '0, "dropped frame with receivers")

   // A slot is either a local peer or a bridge, never both
   `CAFF_ASSERT_NOW(a_mask_disjoint, rsp_valid, (rsp_data.local_mask & rsp_data.bridge_mask) == '0, "slot in both masks")

endmodule

bind channel_aware_frame_fanout caff_checker u_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for channel_aware_frame_fanout: a directed table of
// attach, detach and frame items, then random traffic in six segments with
// different hop limits and stall patterns. Every result is compared against
// a typed value or an in-bench peer table model of the masks and hop count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import caff_pkg::*;

   // Unused fourth operation code, must be ignored by the block
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         SEG_ITEMS   = 217;

   typedef struct {
      caff_req_type item;
      bit           typed;
      caff_rsp_type want;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   caff_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   caff_rsp_type rsp_data;
   logic         csr_write_enable = 1'b0;
   logic [7:0]   csr_write_data = 8'd0;

   // Model of the peer table and hop limit register
   logic              peer_valid  [PEER_SLOTS];
   logic              peer_bridge [PEER_SLOTS];
   logic [FREQ_W-1:0] peer_chan   [PEER_SLOTS];
   logic [FREQ_W-1:0] peer_bond   [PEER_SLOTS];
   logic [TTL_W-1:0]  hop_limit;

   caff_rsp_type     pending_fanout_q[$];
   directed_row_type directed_rows[$];

   int error_count   = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   channel_aware_frame_fanout u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // HT20/HT40 channel match between sender and receiver
   function automatic bit chan_match(input logic [15:0] tx, input logic [15:0] txb,
                                     input logic [15:0] rx, input logic [15:0] rxb);
      if (tx == 0 || rx == 0) return 1'b1;
      if (txb != 0) begin
         if (rx == tx && (rxb == txb || rxb == 0)) return 1'b1;
         if (rx == txb && rxb == 0) return 1'b1;
         return 1'b0;
      end
      if (rx == tx) return 1'b1;
      if (rxb != 0 && tx == rxb) return 1'b1;
      return 1'b0;
   endfunction

   // Applies one item to the table model and returns the fanout it causes
   function automatic caff_rsp_type fanout_predict(input caff_req_type it);
      caff_rsp_type      r;
      logic [FREQ_W-1:0] tx_chan;
      logic [FREQ_W-1:0] tx_bond;
      bit                to_bridges;
      int                s;
      r = '0;
      s = int'(it.peer_slot);
      tx_chan = '0;
      tx_bond = '0;
      case (it.operation)
         OP_ATTACH: begin
            peer_valid[s]  = 1'b1;
            peer_bridge[s] = it.peer_bridge_link;
            peer_chan[s]   = '0;
            peer_bond[s]   = '0;
         end
         OP_DETACH: begin
            peer_valid[s]  = 1'b0;
            peer_bridge[s] = 1'b0;
            peer_chan[s]   = '0;
            peer_bond[s]   = '0;
         end
         OP_FRAME: begin
            if (int'(it.payload_length) < SHORTEST_FRAME ||
                int'(it.payload_length) > MAX_PAYLOAD || !peer_valid[s]) begin
               r.dropped = 1'b1;
            end else begin
               if (int'(it.payload_length) >= CHANNEL_HDR_LEN &&
                   int'(it.header_version) >= CHANNEL_HDR_VERSION) begin
                  tx_chan = it.chan_freq;
                  tx_bond = it.sec_freq;
               end
               if (peer_bridge[s]) begin
                  r.ttl_out  = (it.ttl_in == 8'd0) ? 8'd0 : it.ttl_in - 8'd1;
                  to_bridges = (r.ttl_out != 8'd0);
               end else begin
                  if (tx_chan != 16'd0) begin
                     peer_chan[s] = tx_chan;
                     peer_bond[s] = tx_bond;
                  end
                  to_bridges = 1'b1;
                  r.ttl_out  = hop_limit;
               end
               for (int i = 0; i < MASK_SLOTS; i++) begin
                  if (i != s && peer_valid[i]) begin
                     if (peer_bridge[i])
                        r.bridge_mask[i] = to_bridges;
                     else
                        r.local_mask[i] = chan_match(tx_chan, tx_bond,
                                                     peer_chan[i], peer_bond[i]);
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic caff_req_type make_item(input logic [1:0] op, input int slot,
                                              input bit br, input int len, input int ver,
                                              input int cf, input int bf, input int ttl);
      caff_req_type it;
      it.operation        = op;
      it.peer_slot        = SLOT_W'(slot);
      it.peer_bridge_link = br;
      it.payload_length   = 14'(len);
      it.header_version   = 16'(ver);
      it.chan_freq        = 16'(cf);
      it.sec_freq         = 16'(bf);
      it.ttl_in           = 8'(ttl);
      return it;
   endfunction

   function automatic caff_rsp_type make_rsp(input int lm, input int bm,
                                             input int ttl, input int drop);
      caff_rsp_type r;
      r.local_mask  = 32'(lm);
      r.bridge_mask = 32'(bm);
      r.ttl_out     = 8'(ttl);
      r.dropped     = 1'(drop);
      return r;
   endfunction

   // A few common channels so that match rules get exercised
   function automatic logic [15:0] pick_freq();
      case ($urandom_range(5))
         0:       return 16'd2412;
         1:       return 16'd2432;
         2:       return 16'd2437;
         3:       return 16'd5180;
         4:       return 16'd5200;
         default: return 16'd5745;
      endcase
   endfunction

   // Mostly well-formed frames and table churn, with some malformed items
   function automatic caff_req_type random_item();
      caff_req_type it;
      int           roll;
      it = '0;
      it.chan_freq = 16'($urandom());
      it.sec_freq  = 16'($urandom());
      it.ttl_in    = 8'($urandom());
      roll = $urandom_range(99);
      if (roll < 68)      it.operation = OP_FRAME;
      else if (roll < 83) it.operation = OP_ATTACH;
      else if (roll < 96) it.operation = OP_DETACH;
      else                it.operation = OP_UNUSED;
      it.peer_slot        = SLOT_W'($urandom_range(31));
      it.peer_bridge_link = ($urandom_range(9) < 3);
      roll = $urandom_range(99);
      if (roll < 6)       it.payload_length = 14'($urandom_range(27));
      else if (roll < 10) it.payload_length = 14'($urandom_range(16383));
      else if (roll < 14) it.payload_length = 14'($urandom_range(16383, MAX_PAYLOAD + 1));
      else if (roll < 20) it.payload_length = 14'($urandom_range(39, 28));
      else if (roll < 25) it.payload_length = 14'($urandom_range(MAX_PAYLOAD, 8192));
      else                it.payload_length = 14'($urandom_range(1600, 40));
      roll = $urandom_range(99);
      if (roll < 8)       it.header_version = 16'($urandom_range(1));
      else if (roll < 15) it.header_version = 16'($urandom());
      else                it.header_version = 16'($urandom_range(7, 2));
      roll = $urandom_range(99);
      if (roll < 8)       it.chan_freq = 16'd0;
      else if (roll >= 15) it.chan_freq = pick_freq();
      roll = $urandom_range(99);
      if (roll < 55)      it.sec_freq = 16'd0;
      else if (roll < 75) it.sec_freq = pick_freq();
      else if (roll < 85) it.sec_freq = it.chan_freq + 16'd20;
      if ($urandom_range(99) < 30) it.ttl_in = 8'($urandom_range(2));
      return it;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Send one item, with random idle cycles ahead of it
   task automatic push_item(input caff_req_type it, input bit typed,
                            input caff_rsp_type want);
      caff_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      predicted = fanout_predict(it);
      pending_fanout_q.push_back(typed ? want : predicted);
   endtask

   // Hold the sender until every result is back
   task automatic drain_fanout();
      req_valid <= 1'b0;
      while (pending_fanout_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_hop_limit(input logic [7:0] value);
      drain_fanout();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      hop_limit = value;
   endtask

   // Receiver stalls
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // Result checker
   always @(posedge clock) begin
      caff_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fanout_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_data));
         end else begin
            want = pending_fanout_q.pop_front();
            if (rsp_data.local_mask !== want.local_mask)
               report_mismatch($sformatf("local_mask %h, expected %h",
                                         rsp_data.local_mask, want.local_mask));
            if (rsp_data.bridge_mask !== want.bridge_mask)
               report_mismatch($sformatf("bridge_mask %h, expected %h",
                                         rsp_data.bridge_mask, want.bridge_mask));
            if (rsp_data.ttl_out !== want.ttl_out)
               report_mismatch($sformatf("ttl_out %0d, expected %0d",
                                         rsp_data.ttl_out, want.ttl_out));
            if (rsp_data.dropped !== want.dropped)
               report_mismatch($sformatf("dropped %b, expected %b",
                                         rsp_data.dropped, want.dropped));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus
   initial begin
      caff_rsp_type none;
      logic [7:0]   hop_value;
      none = '0;
      for (int i = 0; i < PEER_SLOTS; i++) begin
         peer_valid[i]  = 1'b0;
         peer_bridge[i] = 1'b0;
         peer_chan[i]   = '0;
         peer_bond[i]   = '0;
      end
      hop_limit = 8'(RESET_HOP_LIMIT);

      // Directed rows: typed results only where obvious
      directed_rows.push_back('{make_item(OP_FRAME, 0, 0, 100, 2, 2412, 0, 5), 1'b1,
                                make_rsp(0, 0, 0, 1)});
      directed_rows.push_back('{make_item(OP_UNUSED, 7, 1, 100, 2, 2412, 0, 5), 1'b1, none});
      directed_rows.push_back('{make_item(OP_DETACH, 5, 0, 0, 0, 0, 0, 0), 1'b1, none});
      directed_rows.push_back('{make_item(OP_ATTACH, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
      directed_rows.push_back('{make_item(OP_ATTACH, 1, 0, 0, 0, 0, 0, 0), 1'b1, none});
      directed_rows.push_back('{make_item(OP_ATTACH, 2, 0, 0, 0, 0, 0, 0), 1'b1, none});
      directed_rows.push_back('{make_item(OP_ATTACH, 3, 1, 0, 0, 0, 0, 0), 1'b1, none});
      directed_rows.push_back('{make_item(OP_ATTACH, 31, 1, 0, 0, 0, 0, 0), 1'b1, none});
      // Length limits
      directed_rows.push_back('{make_item(OP_FRAME, 0, 0, 27, 2, 2412, 0, 5), 1'b1,
                                make_rsp(0, 0, 0, 1)});
      directed_rows.push_back('{make_item(OP_FRAME, 0, 0, 8257, 2, 2412, 0, 5), 1'b1,
                                make_rsp(0, 0, 0, 1)});
      directed_rows.push_back('{make_item(OP_FRAME, 0, 0, 16383, 2, 2412, 0, 5), 1'b1,
                                make_rsp(0, 0, 0, 1)});
      directed_rows.push_back('{make_item(OP_FRAME, 0, 0, 28, 2, 2412, 0, 5), 1'b0, none});
      // Channel learning and HT20/HT40 matching
      directed_rows.push_back('{make_item(OP_FRAME, 0, 0, 40, 2, 2412, 0, 0), 1'b0, none});
      directed_rows.push_back('{make_item(OP_FRAME, 1, 0, 8256, 65535, 5180, 5200, 9),
                                1'b0, none});
      directed_rows.push_back('{make_item(OP_FRAME, 2, 0, 1000, 1, 5745, 0, 9), 1'b0, none});
      directed_rows.push_back('{make_item(OP_FRAME, 2, 0, 500, 3, 2412, 2432, 9), 1'b0, none});
      // Hop counter: bridge sender at zero, one and maximum, then a local sender
      directed_rows.push_back('{make_item(OP_FRAME, 3, 0, 64, 2, 2412, 0, 0), 1'b0, none});
      directed_rows.push_back('{make_item(OP_FRAME, 3, 0, 64, 2, 2412, 0, 1), 1'b0, none});
      directed_rows.push_back('{make_item(OP_FRAME, 31, 1, 64, 2, 65535, 65535, 255),
                                1'b0, none});
      directed_rows.push_back('{make_item(OP_FRAME, 1, 1, 40, 2, 65535, 65535, 255),
                                1'b0, none});
      // Re-attach as bridge, detach, frame from detached slot
      directed_rows.push_back('{make_item(OP_ATTACH, 2, 1, 0, 0, 0, 0, 0), 1'b1, none});
      directed_rows.push_back('{make_item(OP_DETACH, 31, 0, 0, 0, 0, 0, 0), 1'b1, none});
      directed_rows.push_back('{make_item(OP_FRAME, 31, 0, 64, 2, 2412, 0, 4), 1'b1,
                                make_rsp(0, 0, 0, 1)});
      directed_rows.push_back('{make_item(OP_FRAME, 2, 0, 64, 2, 2437, 0, 2), 1'b0, none});

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 31;
      recv_idle_pct = 53;
      foreach (directed_rows[i])
         push_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      // Random segments, hop limit changed at each boundary
      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0:       hop_value = 8'd255;
            1:       hop_value = 8'd0;
            3:       hop_value = 8'd1;
            default: hop_value = 8'($urandom_range(254, 1));
         endcase
         write_hop_limit(hop_value);
         send_idle_pct = (seg < 2) ? 31 : (seg < 4) ? 53 : 0;
         recv_idle_pct = (seg < 2) ? 53 : (seg < 4) ? 31 : 0;
         repeat (SEG_ITEMS) push_item(random_item(), 1'b0, none);
      end

      // Wait for the tail of the pipeline
      req_valid <= 1'b0;
      while (pending_fanout_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
